@@ design/olsi_pkg.sv @@
// Shared types and codes for the ordered list store.
// Used by olsi_cell and ordered_list_store_with_insert_core; depends on nothing.
`default_nettype none

package olsi_pkg;

   localparam int REQ_POS_BITS = 6;
   localparam int RSP_WORD_BITS = 32;
   localparam int RSP_COUNT_BITS = 7;

   typedef enum logic [2:0] {
      FUNC_APPEND = 3'd0,
      FUNC_INSERT = 3'd1,
      FUNC_REMOVE = 3'd2,
      FUNC_READ   = 3'd3,
      FUNC_WRITE  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic shift_en;
      logic load_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ design/olsi_cell.sv @@
// One entry of the list: holds a word, takes its left neighbor's word on an insert shift.
// Depends on olsi_pkg.
`default_nettype none

module olsi_cell
   import olsi_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int POS_BITS = 7,
   parameter int INDEX = 0
) (
   input  wire logic                 clock,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [POS_BITS-1:0]  tgt_pos,
   input  wire logic [WORD_BITS-1:0] load_word,
   input  wire logic [WORD_BITS-1:0] left_word,
   input  wire logic                 rd_en,
   input  wire logic [POS_BITS-1:0]  rd_pos,
   output logic      [WORD_BITS-1:0] word,
   output logic      [WORD_BITS-1:0] rd_word
);

   localparam logic [POS_BITS-1:0] MY_INDEX = POS_BITS'(INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 at_tgt;
   logic                 above_tgt;

   assign at_tgt = (tgt_pos == MY_INDEX);
   assign above_tgt = (MY_INDEX > tgt_pos);

   always_comb begin
      word_in = word_ff;
      if (ctrl.load_en && at_tgt) begin
         word_in = load_word;
      end else if (ctrl.shift_en && above_tgt) begin
         word_in = left_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign rd_word = (rd_en && (rd_pos == MY_INDEX)) ? word_ff : '0;

endmodule

`default_nettype wire

@@ design/ordered_list_store_with_insert_core.sv @@
// Top level of the ordered list store: command decode, entry count and the row of cells.
// Depends on olsi_pkg and olsi_cell.
`default_nettype none

// The block takes one command in every clock cycle; busy stays low. Each command gives one
// result, shown on the rsp_ ports with rsp_strobe for the single cycle after the command is
// taken, and the receiver must take it then. Every entry sits in a cell of its own and all
// cells move at once, so an insert shifts the whole list together, and a read picks
// its entry with an OR of the cells in the result cycle.
module ordered_list_store_with_insert_core
   import olsi_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [2:0]                req_func,
   input  wire logic [REQ_POS_BITS-1:0]   req_position,
   input  wire logic [RSP_WORD_BITS-1:0]  req_data_word,
   output logic                           rsp_strobe,
   output logic      [RSP_WORD_BITS-1:0]  rsp_read_word,
   output logic      [1:0]                rsp_status,
   output logic      [RSP_COUNT_BITS-1:0] rsp_entry_count
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > REQ_POS_BITS) ? CNT_BITS : REQ_POS_BITS;
   localparam int OUT_BITS = (WORD_BITS < RSP_WORD_BITS) ? WORD_BITS : RSP_WORD_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   logic                  accept;
   func_type              func;
   logic [CMP_BITS-1:0]   pos_x;
   logic [CMP_BITS-1:0]   cnt_x;
   logic                  full;
   logic [WORD_BITS-1:0]  word_in;

   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  rsp_strobe_ff;
   status_type            status_ff;
   status_type            status_in;
   logic                  rd_en_ff;
   logic                  rd_en_in;
   logic [CMP_BITS-1:0]   rd_pos_ff;

   cell_ctrl_type         ctrl;
   logic [CMP_BITS-1:0]   tgt_pos;

   logic [WORD_BITS-1:0]  cell_word [DEPTH];
   logic [WORD_BITS-1:0]  cell_rd   [DEPTH];
   logic [WORD_BITS-1:0]  rd_word;
   logic [RSP_WORD_BITS-1:0] rd_ext;

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign func = func_type'(req_func);
   assign pos_x = CMP_BITS'(req_position);
   assign cnt_x = CMP_BITS'(count_ff);
   assign full = (count_ff == FULL_COUNT);
   assign word_in = WORD_BITS'(req_data_word);

   always_comb begin
      count_in = count_ff;
      status_in = ST_OK;
      rd_en_in = 1'b0;
      ctrl = '0;
      tgt_pos = pos_x;
      if (accept) begin
         case (func)
            FUNC_APPEND: begin
               tgt_pos = cnt_x;
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.load_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_INSERT: begin
               if (pos_x > cnt_x) begin
                  status_in = ST_BAD_INDEX;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.load_en = 1'b1;
                  ctrl.shift_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            FUNC_READ: begin
               if (pos_x >= cnt_x) begin
                  status_in = ST_BAD_INDEX;
               end else begin
                  rd_en_in = 1'b1;
               end
            end
            FUNC_WRITE: begin
               if (pos_x >= cnt_x) begin
                  status_in = ST_BAD_INDEX;
               end else begin
                  ctrl.load_en = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_en_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_strobe_ff <= accept;
         rd_en_ff <= rd_en_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_pos_ff <= pos_x;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_rest
         assign left_word = cell_word[i-1];
      end
      olsi_cell #(
         .WORD_BITS (WORD_BITS),
         .POS_BITS  (CMP_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .tgt_pos   (tgt_pos),
         .load_word (word_in),
         .left_word (left_word),
         .rd_en     (rd_en_ff),
         .rd_pos    (rd_pos_ff),
         .word      (cell_word[i]),
         .rd_word   (cell_rd[i])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_word = rd_word | cell_rd[k];
      end
   end

   always_comb begin
      rd_ext = '0;
      rd_ext[OUT_BITS-1:0] = rd_word[OUT_BITS-1:0];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_read_word = rd_ext;
   assign rsp_status = status_ff;
   assign rsp_entry_count = RSP_COUNT_BITS'(count_ff);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("command without result");

   a_no_extra_result : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without command");

   a_zero_on_fail : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_read_word == '0))
      else $error("nonzero read word on failed command");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count moved without a command");

endmodule

`default_nettype wire
